>>> design/bary_pkg.sv
// bary_pkg: shared constants for the barycentric weights unit
// defaults for widths, configuration register indexes and output width
// no dependencies
`default_nettype none

package bary_pkg;

  // default coordinate and weight formats
  localparam int COORD_WIDTH      = 16;
  localparam int WEIGHT_FRAC_BITS = 14;
  localparam int OUT_WIDTH        = 18;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_A = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_B = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_C = CFG_INDEX_W'(2);

endpackage

`default_nettype wire

>>> design/bary_dot.sv
// bary_dot: edge vectors and the five dot products, three register stages
// stage 0 takes a word from the input channel, later stages move on en
// no package dependencies
`default_nettype none

module bary_dot #(
  parameter int CW = 16,
  parameter int DW = 2 * (CW + 1) + 2
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [CW-1:0]         point_x,
  input  wire  signed [CW-1:0]         point_y,
  input  wire  signed [CW-1:0]         point_z,
  input  wire         [2:0][CW-1:0]    va,
  input  wire         [2:0][CW-1:0]    vb,
  input  wire         [2:0][CW-1:0]    vc,
  output logic                         out_valid,
  output logic signed [DW-1:0]         d00,
  output logic signed [DW-1:0]         d01,
  output logic signed [DW-1:0]         d11,
  output logic signed [DW-1:0]         d20,
  output logic signed [DW-1:0]         d21
);

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;

  logic                 v0_r, v1_r, v2_r;
  logic                 ld0;
  logic [2:0][CW-1:0]   pt;
  logic signed [EW-1:0] e0_r [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [PW-1:0] p00_r [3];
  logic signed [PW-1:0] p01_r [3];
  logic signed [PW-1:0] p11_r [3];
  logic signed [PW-1:0] p20_r [3];
  logic signed [PW-1:0] p21_r [3];
  logic signed [DW-1:0] d00_r, d01_r, d11_r, d20_r, d21_r;

  // stage 0 loads when the pipeline advances or when it is empty
  assign ld0      = en || !v0_r;
  assign in_ready = ld0;
  assign pt       = {point_z, point_y, point_x};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ld0) begin
        v0_r <= in_valid;
      end
      if (en) begin
        v1_r <= v0_r;
        v2_r <= v1_r;
      end
    end
  end

  // stage 0: edge vectors
  always_ff @(posedge clk) begin
    if (ld0) begin
      for (int k = 0; k < 3; k++) begin
        e0_r[k] <= $signed({vb[k][CW-1], vb[k]}) - $signed({va[k][CW-1], va[k]});
        e1_r[k] <= $signed({vc[k][CW-1], vc[k]}) - $signed({va[k][CW-1], va[k]});
        e2_r[k] <= $signed({pt[k][CW-1], pt[k]}) - $signed({va[k][CW-1], va[k]});
      end
    end
  end

  // stage 1: per-axis products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p00_r[k] <= PW'(e0_r[k]) * PW'(e0_r[k]);
        p01_r[k] <= PW'(e0_r[k]) * PW'(e1_r[k]);
        p11_r[k] <= PW'(e1_r[k]) * PW'(e1_r[k]);
        p20_r[k] <= PW'(e2_r[k]) * PW'(e0_r[k]);
        p21_r[k] <= PW'(e2_r[k]) * PW'(e1_r[k]);
      end
    end
  end

  // stage 2: sums over the axes
  always_ff @(posedge clk) begin
    if (en) begin
      d00_r <= DW'(p00_r[0]) + DW'(p00_r[1]) + DW'(p00_r[2]);
      d01_r <= DW'(p01_r[0]) + DW'(p01_r[1]) + DW'(p01_r[2]);
      d11_r <= DW'(p11_r[0]) + DW'(p11_r[1]) + DW'(p11_r[2]);
      d20_r <= DW'(p20_r[0]) + DW'(p20_r[1]) + DW'(p20_r[2]);
      d21_r <= DW'(p21_r[0]) + DW'(p21_r[1]) + DW'(p21_r[2]);
    end
  end

  assign out_valid = v2_r;
  assign d00       = d00_r;
  assign d01       = d01_r;
  assign d11       = d11_r;
  assign d20       = d20_r;
  assign d21       = d21_r;

endmodule

`default_nettype wire

>>> design/bary_mul.sv
// bary_mul: denominator and the two numerators from the dot products
// wide products split in half-width partial products, three register stages
// no package dependencies
`default_nettype none

module bary_mul #(
  parameter int DW = 36,
  parameter int NW = 2 * DW + 1
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_valid,
  input  wire  signed [DW-1:0] d00,
  input  wire  signed [DW-1:0] d01,
  input  wire  signed [DW-1:0] d11,
  input  wire  signed [DW-1:0] d20,
  input  wire  signed [DW-1:0] d21,
  output logic                 out_valid,
  output logic signed [NW-1:0] denom,
  output logic signed [NW-1:0] num_v,
  output logic signed [NW-1:0] num_w
);

  localparam int H   = DW / 2;
  localparam int HW  = DW - H;
  localparam int LW  = DW + H + 1;
  localparam int UPW = DW + HW;
  localparam int PW  = 2 * DW;

  logic                  v1_r, v2_r, v3_r;
  logic signed [DW-1:0]  a_op [6];
  logic signed [DW-1:0]  b_op [6];
  logic signed [LW-1:0]  plo_r [6];
  logic signed [UPW-1:0] phi_r [6];
  logic signed [PW-1:0]  prod_r [6];
  logic signed [NW-1:0]  denom_r, num_v_r, num_w_r;

  // operand pairs: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
  assign a_op[0] = d00;  assign b_op[0] = d11;
  assign a_op[1] = d01;  assign b_op[1] = d01;
  assign a_op[2] = d11;  assign b_op[2] = d20;
  assign a_op[3] = d01;  assign b_op[3] = d21;
  assign a_op[4] = d00;  assign b_op[4] = d21;
  assign a_op[5] = d01;  assign b_op[5] = d20;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: low half unsigned, high half signed partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        plo_r[i] <= LW'(a_op[i]) * LW'($signed({1'b0, b_op[i][H-1:0]}));
        phi_r[i] <= UPW'(a_op[i]) * UPW'($signed(b_op[i][DW-1:H]));
      end
    end
  end

  // stage 2: full products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        prod_r[i] <= (PW'(phi_r[i]) <<< H) + PW'(plo_r[i]);
      end
    end
  end

  // stage 3: differences
  always_ff @(posedge clk) begin
    if (en) begin
      denom_r <= NW'(prod_r[0]) - NW'(prod_r[1]);
      num_v_r <= NW'(prod_r[2]) - NW'(prod_r[3]);
      num_w_r <= NW'(prod_r[4]) - NW'(prod_r[5]);
    end
  end

  assign out_valid = v3_r;
  assign denom     = denom_r;
  assign num_v     = num_v_r;
  assign num_w     = num_w_r;

endmodule

`default_nettype wire

>>> design/bary_div.sv
// bary_div: pipelined restoring divider, two lanes sharing one divisor
// one quotient bit per stage, then round-half-away and sign stages
// no package dependencies
`default_nettype none

module bary_div #(
  parameter int NW   = 73,
  parameter int FRAC = 14,
  parameter int SW   = NW + FRAC + 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_valid,
  input  wire  signed [NW-1:0] denom,
  input  wire  signed [NW-1:0] num_v,
  input  wire  signed [NW-1:0] num_w,
  output logic                 out_valid,
  output logic                 degen,
  output logic signed [SW-1:0] quot_v,
  output logic signed [SW-1:0] quot_w
);

  localparam int QW = NW + FRAC;
  localparam int RW = NW - 1;

  logic [QW:0]   vld_r;
  logic [RW-1:0] d_r     [QW+1];
  logic          degen_r [QW+1];
  logic          neg_v_r [QW+1];
  logic          neg_w_r [QW+1];
  logic [RW-1:0] rem_v_r [QW+1];
  logic [RW-1:0] rem_w_r [QW+1];
  logic [QW-1:0] dq_v_r  [QW+1];
  logic [QW-1:0] dq_w_r  [QW+1];

  logic          vr_r, vs_r;
  logic          degen_rd_r, degen_s_r;
  logic          neg_v_rd_r, neg_w_rd_r;
  logic [QW:0]   qv_r, qw_r;
  logic signed [SW-1:0] sv_r, sw_r;
  logic [NW-1:0] mag_v, mag_w;

  // valid bits through the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vr_r  <= 1'b0;
      vs_r  <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_valid};
      vr_r  <= vld_r[QW];
      vs_r  <= vr_r;
    end
  end

  // prep stage: magnitudes and divisor
  assign mag_v = num_v[NW-1] ? NW'(-num_v) : NW'(num_v);
  assign mag_w = num_w[NW-1] ? NW'(-num_w) : NW'(num_w);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]     <= denom[RW-1:0];
      degen_r[0] <= (denom == '0) || denom[NW-1];
      neg_v_r[0] <= num_v[NW-1];
      neg_w_r[0] <= num_w[NW-1];
      rem_v_r[0] <= '0;
      rem_w_r[0] <= '0;
      dq_v_r[0]  <= {mag_v, {FRAC{1'b0}}};
      dq_w_r[0]  <= {mag_w, {FRAC{1'b0}}};
    end
  end

  // one quotient bit per stage; dividend bits leave the top, quotient bits enter below
  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [NW-1:0] t_v, t_w, dz;
    logic          ge_v, ge_w;
    logic [NW-1:0] diff_v, diff_w;

    assign dz     = {1'b0, d_r[s-1]};
    assign t_v    = {rem_v_r[s-1], dq_v_r[s-1][QW-1]};
    assign t_w    = {rem_w_r[s-1], dq_w_r[s-1][QW-1]};
    assign ge_v   = t_v >= dz;
    assign ge_w   = t_w >= dz;
    assign diff_v = t_v - dz;
    assign diff_w = t_w - dz;

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s]     <= d_r[s-1];
        degen_r[s] <= degen_r[s-1];
        neg_v_r[s] <= neg_v_r[s-1];
        neg_w_r[s] <= neg_w_r[s-1];
        rem_v_r[s] <= ge_v ? diff_v[RW-1:0] : t_v[RW-1:0];
        rem_w_r[s] <= ge_w ? diff_w[RW-1:0] : t_w[RW-1:0];
        dq_v_r[s]  <= {dq_v_r[s-1][QW-2:0], ge_v};
        dq_w_r[s]  <= {dq_w_r[s-1][QW-2:0], ge_w};
      end
    end
  end

  // round: add one when twice the remainder reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      qv_r       <= (QW+1)'(dq_v_r[QW]) +
                    (QW+1)'({rem_v_r[QW], 1'b0} >= {1'b0, d_r[QW]});
      qw_r       <= (QW+1)'(dq_w_r[QW]) +
                    (QW+1)'({rem_w_r[QW], 1'b0} >= {1'b0, d_r[QW]});
      neg_v_rd_r <= neg_v_r[QW];
      neg_w_rd_r <= neg_w_r[QW];
      degen_rd_r <= degen_r[QW];
    end
  end

  // restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      sv_r      <= neg_v_rd_r ? -SW'(qv_r) : SW'(qv_r);
      sw_r      <= neg_w_rd_r ? -SW'(qw_r) : SW'(qw_r);
      degen_s_r <= degen_rd_r;
    end
  end

  assign out_valid = vs_r;
  assign degen     = degen_s_r;
  assign quot_v    = sv_r;
  assign quot_w    = sw_r;

endmodule

`default_nettype wire

>>> design/triangle_barycentric_weights_unit.sv
// triangle_barycentric_weights_unit: top level of the barycentric weights unit
// uses bary_pkg, bary_dot, bary_mul and bary_div
//
// Usage: write the three vertices through the cfg_ port (index 0, 1, 2 for
// vertices a, b, c; other indexes are ignored), only while no point is in
// flight. cfg_ready is always high. Points enter on in_valid/in_stall, one
// word per cycle while in_stall is low; each gives one result word on
// out_valid/out_stall with weights u, v, w (signed, WEIGHT_FRAC_BITS fraction
// bits, saturated) and the degenerate and saturated flags.
// The divider spends one stage per quotient bit.
// Throughput: one point per cycle when the output is not stalled.
// Stall: out_stall, while a result waits in the output register, freezes
// the whole pipeline behind it; the first stage still takes one more word
// if it is empty. Nothing is dropped or repeated. Reset clears the vertices
// to zero and empties the pipeline.
`default_nettype none

module triangle_barycentric_weights_unit #(
  parameter int COORD_WIDTH      = bary_pkg::COORD_WIDTH,
  parameter int WEIGHT_FRAC_BITS = bary_pkg::WEIGHT_FRAC_BITS
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [bary_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [bary_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [COORD_WIDTH-1:0]         in_point_x,
  input  wire  signed [COORD_WIDTH-1:0]         in_point_y,
  input  wire  signed [COORD_WIDTH-1:0]         in_point_z,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [bary_pkg::OUT_WIDTH-1:0] out_weight_u,
  output logic signed [bary_pkg::OUT_WIDTH-1:0] out_weight_v,
  output logic signed [bary_pkg::OUT_WIDTH-1:0] out_weight_w,
  output logic                                  out_degenerate,
  output logic                                  out_saturated
);

  localparam int CW    = COORD_WIDTH;
  localparam int FRAC  = WEIGHT_FRAC_BITS;
  localparam int OW    = bary_pkg::OUT_WIDTH;
  localparam int DATW  = bary_pkg::CFG_DATA_W;
  localparam int DW    = 2 * (CW + 1) + 2;
  localparam int NW    = 2 * DW + 1;
  localparam int SW    = NW + FRAC + 2;
  localparam int UW    = SW + 2;
  localparam int VW    = (3 * CW > DATW) ? 3 * CW : DATW;
  localparam int CHK_W = OW + 2;
  localparam logic signed [UW-1:0] SAT_HI = UW'(2 ** (OW - 1) - 1);
  localparam logic signed [UW-1:0] SAT_LO = UW'(-(2 ** (OW - 1)));

  logic [DATW-1:0]     vertex_a_r, vertex_b_r, vertex_c_r;
  logic [VW-1:0]       ext_a, ext_b, ext_c;
  logic [2:0][CW-1:0]  va, vb, vc;
  logic                en, dot_ready;
  logic                dot_valid, mul_valid, div_valid;
  logic signed [DW-1:0] d00, d01, d11, d20, d21;
  logic signed [NW-1:0] denom, num_v, num_w;
  logic                 degen;
  logic signed [SW-1:0] quot_v, quot_w;

  logic                 vu_r, degen_u_r;
  logic signed [UW-1:0] u_r, v_r, w_r;
  logic                 out_valid_r;
  logic signed [OW-1:0] wu_r, wv_r, ww_r;
  logic                 degen_out_r, sat_out_r;
  logic                 sat_u, sat_v, sat_w;
  logic signed [OW-1:0] cu, cv, cw;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_a_r <= '0;
      vertex_b_r <= '0;
      vertex_c_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bary_pkg::REG_VERTEX_A: vertex_a_r <= cfg_data;
        bary_pkg::REG_VERTEX_B: vertex_b_r <= cfg_data;
        bary_pkg::REG_VERTEX_C: vertex_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack vertex coordinates
  assign ext_a = VW'(vertex_a_r);
  assign ext_b = VW'(vertex_b_r);
  assign ext_c = VW'(vertex_c_r);

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign va[k] = ext_a[k*CW +: CW];
    assign vb[k] = ext_b[k*CW +: CW];
    assign vc[k] = ext_c[k*CW +: CW];
  end

  // pipeline advances unless a result waits on a stalled output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !dot_ready;

  bary_dot #(.CW(CW), .DW(DW)) u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_ready  (dot_ready),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .point_z   (in_point_z),
    .va        (va),
    .vb        (vb),
    .vc        (vc),
    .out_valid (dot_valid),
    .d00       (d00),
    .d01       (d01),
    .d11       (d11),
    .d20       (d20),
    .d21       (d21)
  );

  bary_mul #(.DW(DW), .NW(NW)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dot_valid),
    .d00       (d00),
    .d01       (d01),
    .d11       (d11),
    .d20       (d20),
    .d21       (d21),
    .out_valid (mul_valid),
    .denom     (denom),
    .num_v     (num_v),
    .num_w     (num_w)
  );

  bary_div #(.NW(NW), .FRAC(FRAC), .SW(SW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mul_valid),
    .denom     (denom),
    .num_v     (num_v),
    .num_w     (num_w),
    .out_valid (div_valid),
    .degen     (degen),
    .quot_v    (quot_v),
    .quot_w    (quot_w)
  );

  // u stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vu_r <= 1'b0;
    end else if (en) begin
      vu_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r       <= UW'(1 << FRAC) - UW'(quot_v) - UW'(quot_w);
      v_r       <= UW'(quot_v);
      w_r       <= UW'(quot_w);
      degen_u_r <= degen;
    end
  end

  // saturation
  always_comb begin
    sat_u = (u_r > SAT_HI) || (u_r < SAT_LO);
    sat_v = (v_r > SAT_HI) || (v_r < SAT_LO);
    sat_w = (w_r > SAT_HI) || (w_r < SAT_LO);
    cu    = (u_r > SAT_HI) ? SAT_HI[OW-1:0] : (u_r < SAT_LO) ? SAT_LO[OW-1:0] : u_r[OW-1:0];
    cv    = (v_r > SAT_HI) ? SAT_HI[OW-1:0] : (v_r < SAT_LO) ? SAT_LO[OW-1:0] : v_r[OW-1:0];
    cw    = (w_r > SAT_HI) ? SAT_HI[OW-1:0] : (w_r < SAT_LO) ? SAT_LO[OW-1:0] : w_r[OW-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vu_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wu_r        <= degen_u_r ? '0 : cu;
      wv_r        <= degen_u_r ? '0 : cv;
      ww_r        <= degen_u_r ? '0 : cw;
      degen_out_r <= degen_u_r;
      sat_out_r   <= !degen_u_r && (sat_u || sat_v || sat_w);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_weight_u   = wu_r;
  assign out_weight_v   = wv_r;
  assign out_weight_w   = ww_r;
  assign out_degenerate = degen_out_r;
  assign out_saturated  = sat_out_r;

  // degenerate word carries zero weights and no saturation
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_weight_u == '0 && out_weight_v == '0 && out_weight_w == '0 && !out_saturated))
    else $error("degenerate word with nonzero weights");

  // an unclamped word has weights that sum to one
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate && !out_saturated) |->
      ((CHK_W'(out_weight_u) + CHK_W'(out_weight_v) + CHK_W'(out_weight_w))
        == CHK_W'(1 << FRAC)))
    else $error("weights do not sum to one");

  // a saturated word has some weight at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_weight_u == SAT_HI[OW-1:0] || out_weight_u == SAT_LO[OW-1:0] ||
       out_weight_v == SAT_HI[OW-1:0] || out_weight_v == SAT_LO[OW-1:0] ||
       out_weight_w == SAT_HI[OW-1:0] || out_weight_w == SAT_LO[OW-1:0]))
    else $error("saturated flag without a clamped weight");

  // a stalled output word freezes the stage behind it
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(u_r) && $stable(vu_r)))
    else $error("pipeline moved under a stalled output");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench: self-checking bench for triangle_barycentric_weights_unit
// predicts weights for each accepted point and checks every output word
// depends on bary_pkg and the unit's RTL
`default_nettype none

module testbench;

  localparam int LATENCY =
    4 * bary_pkg::COORD_WIDTH + bary_pkg::WEIGHT_FRAC_BITS + 20;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int OW = bary_pkg::OUT_WIDTH;

  typedef struct packed {
    logic signed [bary_pkg::OUT_WIDTH-1:0] u;
    logic signed [bary_pkg::OUT_WIDTH-1:0] v;
    logic signed [bary_pkg::OUT_WIDTH-1:0] w;
    logic                                  degen;
    logic                                  sat;
  } weights_t;

  // predicted weights, oldest first
  class weight_board;
    logic [bary_pkg::CFG_DATA_W-1:0] vtx [3];
    weights_t pending [$];
    int mismatches;

    function void set_vertex(logic [bary_pkg::CFG_INDEX_W-1:0] idx,
                             logic [bary_pkg::CFG_DATA_W-1:0] d);
      if (idx == bary_pkg::REG_VERTEX_A) vtx[0] = d;
      else if (idx == bary_pkg::REG_VERTEX_B) vtx[1] = d;
      else if (idx == bary_pkg::REG_VERTEX_C) vtx[2] = d;
    endfunction

    function logic signed [127:0] clamp(logic signed [127:0] x, ref logic sat);
      logic signed [127:0] lo;
      logic signed [127:0] hi;
      lo = -(128'sd1 <<< (OW - 1));
      hi = (128'sd1 <<< (OW - 1)) - 128'sd1;
      if (x < lo) begin sat = 1'b1; return lo; end
      if (x > hi) begin sat = 1'b1; return hi; end
      return x;
    endfunction

    // scaled quotient, rounded half away from zero
    function logic signed [127:0] scaled_div(logic signed [127:0] n, logic signed [127:0] d);
      logic [127:0] mag;
      logic [127:0] q;
      logic [127:0] r;
      mag = (n < 0) ? -n : n;
      mag = mag << bary_pkg::WEIGHT_FRAC_BITS;
      q = mag / d;
      r = mag % d;
      if ((r << 1) >= d) q = q + 128'd1;
      return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    function void note_point(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] pz);
      logic signed [63:0] a [3];
      logic signed [63:0] e0 [3];
      logic signed [63:0] e1 [3];
      logic signed [63:0] e2 [3];
      logic signed [63:0] p [3];
      logic signed [63:0] d00, d01, d11, d20, d21;
      logic signed [127:0] den, nv, nw, v, w, u;
      logic sat;
      weights_t r;
      p[0] = 64'(px); p[1] = 64'(py); p[2] = 64'(pz);
      d00 = '0; d01 = '0; d11 = '0; d20 = '0; d21 = '0;
      for (int k = 0; k < 3; k++) begin
        a[k] = 64'($signed(vtx[0][k*16 +: 16]));
        e0[k] = 64'($signed(vtx[1][k*16 +: 16])) - a[k];
        e1[k] = 64'($signed(vtx[2][k*16 +: 16])) - a[k];
        e2[k] = p[k] - a[k];
        d00 += e0[k] * e0[k];
        d01 += e0[k] * e1[k];
        d11 += e1[k] * e1[k];
        d20 += e2[k] * e0[k];
        d21 += e2[k] * e1[k];
      end
      den = 128'(d00) * 128'(d11) - 128'(d01) * 128'(d01);
      r = '0;
      if (den <= 0) begin
        r.degen = 1'b1;
      end else begin
        nv = 128'(d11) * 128'(d20) - 128'(d01) * 128'(d21);
        nw = 128'(d00) * 128'(d21) - 128'(d01) * 128'(d20);
        v = scaled_div(nv, den);
        w = scaled_div(nw, den);
        u = (128'sd1 <<< bary_pkg::WEIGHT_FRAC_BITS) - v - w;
        sat = 1'b0;
        r.u = OW'(clamp(u, sat));
        r.v = OW'(clamp(v, sat));
        r.w = OW'(clamp(w, sat));
        r.sat = sat;
      end
      pending.push_back(r);
    endfunction

    function void check_word(weights_t got);
      weights_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %p", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"weights mismatch: expected u=%0d v=%0d w=%0d deg=%0b sat=%0b,",
                    " got u=%0d v=%0d w=%0d deg=%0b sat=%0b"},
                   exp_w.u, exp_w.v, exp_w.w, exp_w.degen, exp_w.sat,
                   got.u, got.v, got.w, got.degen, got.sat);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [bary_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bary_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [bary_pkg::COORD_WIDTH-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [bary_pkg::OUT_WIDTH-1:0] out_weight_u, out_weight_v, out_weight_w;
  logic out_degenerate, out_saturated;

  weight_board board;
  bit quiet_tail = 0;
  longint cycles = 0;

  triangle_barycentric_weights_unit dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // accepted words go to the board at the clock edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) board.note_point(in_point_x, in_point_y, in_point_z);
    if (rst_n && out_valid && !out_stall)
      board.check_word({out_weight_u, out_weight_v, out_weight_w, out_degenerate, out_saturated});
    if (cycles > CYCLE_LIMIT) begin
      $display("[triangle_barycentric_weights_unit] ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic write_vertex(logic [bary_pkg::CFG_INDEX_W-1:0] idx,
                              logic [bary_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    board.set_vertex(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [47:0] pack(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  // random vertex coordinate, sometimes at the extremes
  function automatic logic [15:0] coord(int span);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  initial begin
    int span;
    board = new();
    board.vtx = '{default: '0};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: all-zero vertices give a degenerate triangle
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h7fff, 16'h8000, 16'hffff);
    drain();

    // right triangle with legs of 1024 in xy, points inside, on vertices and far outside
    write_vertex(bary_pkg::REG_VERTEX_A, pack(16'd0, 16'd0, 16'd0));
    write_vertex(bary_pkg::REG_VERTEX_B, pack(16'd1024, 16'd0, 16'd0));
    write_vertex(bary_pkg::REG_VERTEX_C, pack(16'd0, 16'd1024, 16'd0));
    write_vertex(2'd3, 48'hffff_ffff_ffff);
    send_point(16'd0, 16'd0, 16'd0);
    send_point(16'd1024, 16'd0, 16'd0);
    send_point(16'd0, 16'd1024, 16'd0);
    send_point(16'd341, 16'd341, 16'd77);
    send_point(16'd3, 16'd1, 16'd0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h8000, 16'h0000);
    drain();

    // extreme vertices, collinear set (degenerate) then full-range triangle
    write_vertex(bary_pkg::REG_VERTEX_A, pack(16'h8000, 16'h8000, 16'h8000));
    write_vertex(bary_pkg::REG_VERTEX_B, pack(16'h7fff, 16'h7fff, 16'h7fff));
    write_vertex(bary_pkg::REG_VERTEX_C, pack(16'h0000, 16'h0000, 16'h0000));
    send_point(16'h1234, 16'h8000, 16'h7fff);
    drain();
    write_vertex(bary_pkg::REG_VERTEX_C, pack(16'h7fff, 16'h8000, 16'h7fff));
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h0000, 16'h7fff, 16'h8000);
    drain();

    // random triangles with random points near and far
    for (int ph = 0; ph < 30; ph++) begin
      span = (ph % 3 == 0) ? 32767 : (ph % 3 == 1) ? 2000 : 40;
      write_vertex(bary_pkg::REG_VERTEX_A, pack(coord(span), coord(span), coord(span)));
      write_vertex(bary_pkg::REG_VERTEX_B, pack(coord(span), coord(span), coord(span)));
      if (ph % 7 == 3) write_vertex(bary_pkg::REG_VERTEX_C, board.vtx[1]);
      else write_vertex(bary_pkg::REG_VERTEX_C, pack(coord(span), coord(span), coord(span)));
      if (ph == 27) quiet_tail = 1;
      for (int i = 0; i < 30; i++)
        send_point(16'($urandom), 16'($urandom), 16'($urandom));
      drain();
    end

    if (board.mismatches == 0) $display("[triangle_barycentric_weights_unit] OK");
    else $display("[triangle_barycentric_weights_unit] ERROR");
    $finish;
  end
endmodule

`default_nettype wire

>>> files.f
design/bary_pkg.sv
design/bary_dot.sv
design/bary_mul.sv
design/bary_div.sv
design/triangle_barycentric_weights_unit.sv
tb/sv/testbench.sv
